/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked same-cycle-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SLE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define SLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// Shared codes, sequencer states and compare-result type of the list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam logic [2:0] OP_GET    = 3'd0;
   localparam logic [2:0] OP_LOCATE = 3'd1;
   localparam logic [2:0] OP_INSERT = 3'd2;
   localparam logic [2:0] OP_DELETE = 3'd3;
   localparam logic [2:0] OP_MERGE  = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_GET_WAIT,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_INS_RD,
      S_INS_WR,
      S_DEL_RD,
      S_DEL_WR,
      S_SORT_OUTER,
      S_SORT_KEY,
      S_SORT_RD,
      S_SORT_CMP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic eq;   // a == b
      logic gt;   // a > b, signed
   } cmp_res_type;

endpackage

/* hdl/sequential_list_engine_top.sv */
// ----------------------------------------------------------------------------
// sequential_list_engine_top
// Ordered list of signed words with get, locate, insert, delete, merge/sort.
// ----------------------------------------------------------------------------
// Usage:
//  One item on the req_ channel carries operation, position, value and the
//  last-of-merge mark. It is taken when req_valid is high and req_stall low.
//  req_stall is high from acceptance until the sequencer is back in idle,
//  so one item is worked on at a time. Each item yields exactly one item on
//  the rsp_ channel, held in an output register until rsp_stall is low.
//  A new request may be accepted while that result still waits; the next
//  result then waits in the finish step until the output register frees.
// Work per item, all of it through the one element store:
//  get reads one entry, locate scans from the front until a hit or the
//  count, insert shifts the entries from pos up toward the end, delete
//  shifts the entries above pos toward the front, merge appends one value;
//  merge with the last mark then adds the insertion sort over the list.
// Reset (synchronous, active high) empties the list and drops any result.
// The store itself is not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
module sequential_list_engine_top #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   input  logic               req_last_of_merge,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_read_value,
   output logic [5:0]         rsp_found_index,
   output logic               rsp_found,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_list_length,
   output logic               rsp_is_empty
);

`include "assert_macros.svh"

   // address, count and wide-compare widths
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ((CW > 7) ? CW : 7) + 1;

   sle_pkg::state_type state_ff, state_in;

   // control state
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // working registers (no reset)
   logic [2:0]         op_ff, op_in;
   logic [6:0]         pos_ff, pos_in;
   logic               last_ff, last_in;
   logic signed [31:0] key_ff, key_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic signed [31:0] res_value_ff, res_value_in;
   logic [5:0]         res_idx_ff, res_idx_in;
   logic               res_found_ff, res_found_in;
   logic [1:0]         status_ff, status_in;

   // output register
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [5:0]         rsp_idx_ff, rsp_idx_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [6:0]         rsp_len_ff, rsp_len_in;
   logic               rsp_empty_ff, rsp_empty_in;

   // memory port
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic signed [31:0] mem_wr_data;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   logic signed [31:0] mem_rd_data;

   sle_pkg::cmp_res_type cmp_res;

   // widened views for range checks
   logic [PW-1:0] pos_x, cnt_x, i_x, j_x, cap_x;
   logic [PW-1:0] pos_m1, i_m1, j_m1;
   logic          req_take, rsp_load;

   assign pos_x  = PW'(pos_ff);
   assign cnt_x  = PW'(cnt_ff);
   assign i_x    = PW'(i_ff);
   assign j_x    = PW'(j_ff);
   assign cap_x  = PW'(CAPACITY);
   assign pos_m1 = pos_x - 1'b1;
   assign i_m1   = i_x - 1'b1;
   assign j_m1   = j_x - 1'b1;

   assign req_stall = (state_ff != sle_pkg::S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == sle_pkg::S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   sle_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // key holds the request value for locate, the sort key during the sort
   sle_cmp u_cmp (
      .a   (key_ff),
      .b   (mem_rd_data),
      .res (cmp_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      last_ff       <= last_in;
      key_ff        <= key_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      res_value_ff  <= res_value_in;
      res_idx_ff    <= res_idx_in;
      res_found_ff  <= res_found_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      key_in       = key_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      res_value_in = res_value_ff;
      res_idx_in   = res_idx_ff;
      res_found_in = res_found_ff;
      status_in    = status_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = i_ff[AW-1:0];
      mem_wr_data  = key_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = i_ff[AW-1:0];

      case (state_ff)
         sle_pkg::S_IDLE: begin
            if (req_take) begin
               op_in        = req_operation;
               pos_in       = req_position;
               last_in      = req_last_of_merge;
               key_in       = req_value;
               res_value_in = '0;
               res_idx_in   = '0;
               res_found_in = 1'b0;
               status_in    = sle_pkg::ST_OK;
               state_in     = sle_pkg::S_DECODE;
            end
         end
         sle_pkg::S_DECODE: begin
            case (op_ff)
               sle_pkg::OP_GET: begin
                  if (pos_x >= PW'(1) && pos_x <= cnt_x) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = pos_m1[AW-1:0];
                     state_in    = sle_pkg::S_GET_WAIT;
                  end else begin
                     status_in = sle_pkg::ST_RANGE;
                     state_in  = sle_pkg::S_FINISH;
                  end
               end
               sle_pkg::OP_LOCATE: begin
                  i_in     = '0;
                  state_in = sle_pkg::S_SCAN_RD;
               end
               sle_pkg::OP_INSERT: begin
                  if (cnt_x >= cap_x) begin
                     status_in = sle_pkg::ST_FULL;
                     state_in  = sle_pkg::S_FINISH;
                  end else if (pos_x < PW'(1) || pos_x > cnt_x + 1'b1) begin
                     status_in = sle_pkg::ST_RANGE;
                     state_in  = sle_pkg::S_FINISH;
                  end else begin
                     i_in     = cnt_ff;
                     state_in = sle_pkg::S_INS_RD;
                  end
               end
               sle_pkg::OP_DELETE: begin
                  if (pos_x < PW'(1) || pos_x > cnt_x) begin
                     status_in = sle_pkg::ST_RANGE;
                     state_in  = sle_pkg::S_FINISH;
                  end else begin
                     i_in     = pos_x[CW-1:0];
                     state_in = sle_pkg::S_DEL_RD;
                  end
               end
               sle_pkg::OP_MERGE: begin
                  if (cnt_x >= cap_x) begin
                     status_in = sle_pkg::ST_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = cnt_ff[AW-1:0];
                     cnt_in      = cnt_ff + 1'b1;
                  end
                  if (last_ff) begin
                     i_in     = CW'(1);
                     state_in = sle_pkg::S_SORT_OUTER;
                  end else begin
                     state_in = sle_pkg::S_FINISH;
                  end
               end
               default: begin
                  state_in = sle_pkg::S_FINISH;
               end
            endcase
         end
         sle_pkg::S_GET_WAIT: begin
            res_value_in = mem_rd_data;
            res_found_in = 1'b1;
            state_in     = sle_pkg::S_FINISH;
         end
         sle_pkg::S_SCAN_RD: begin
            if (i_x >= cnt_x) begin
               state_in = sle_pkg::S_FINISH;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = sle_pkg::S_SCAN_CMP;
            end
         end
         sle_pkg::S_SCAN_CMP: begin
            if (cmp_res.eq) begin
               res_found_in = 1'b1;
               res_idx_in   = i_x[5:0];
               state_in     = sle_pkg::S_FINISH;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = sle_pkg::S_SCAN_RD;
            end
         end
         // shift toward the end, from the top down to the insert point
         sle_pkg::S_INS_RD: begin
            if (i_x >= pos_x) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = i_m1[AW-1:0];
               state_in    = sle_pkg::S_INS_WR;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pos_m1[AW-1:0];
               cnt_in      = cnt_ff + 1'b1;
               state_in    = sle_pkg::S_FINISH;
            end
         end
         sle_pkg::S_INS_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data;
            i_in        = i_ff - 1'b1;
            state_in    = sle_pkg::S_INS_RD;
         end
         // shift toward the front, from the delete point up
         sle_pkg::S_DEL_RD: begin
            if (i_x < cnt_x) begin
               mem_rd_en = 1'b1;
               state_in  = sle_pkg::S_DEL_WR;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = sle_pkg::S_FINISH;
            end
         end
         sle_pkg::S_DEL_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = i_m1[AW-1:0];
            mem_wr_data = mem_rd_data;
            i_in        = i_ff + 1'b1;
            state_in    = sle_pkg::S_DEL_RD;
         end
         // insertion sort, descending
         sle_pkg::S_SORT_OUTER: begin
            if (i_x >= cnt_x) begin
               state_in = sle_pkg::S_FINISH;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = sle_pkg::S_SORT_KEY;
            end
         end
         sle_pkg::S_SORT_KEY: begin
            key_in   = mem_rd_data;
            j_in     = i_ff;
            state_in = sle_pkg::S_SORT_RD;
         end
         sle_pkg::S_SORT_RD: begin
            if (j_x == '0) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = j_ff[AW-1:0];
               i_in        = i_ff + 1'b1;
               state_in    = sle_pkg::S_SORT_OUTER;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = j_m1[AW-1:0];
               state_in    = sle_pkg::S_SORT_CMP;
            end
         end
         sle_pkg::S_SORT_CMP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = j_ff[AW-1:0];
            if (cmp_res.gt) begin
               mem_wr_data = mem_rd_data;
               j_in        = j_ff - 1'b1;
               state_in    = sle_pkg::S_SORT_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = sle_pkg::S_SORT_OUTER;
            end
         end
         sle_pkg::S_FINISH: begin
            if (rsp_load) begin
               state_in = sle_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sle_pkg::S_IDLE;
         end
      endcase
   end

   // output register: loads from finish, holds while stalled
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_idx_in    = res_idx_ff;
         rsp_found_in  = res_found_ff;
         rsp_status_in = status_ff;
         rsp_len_in    = cnt_x[6:0];
         rsp_empty_in  = (cnt_ff == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_found_index = rsp_idx_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_list_length = rsp_len_ff;
   assign rsp_is_empty    = rsp_empty_ff;

   // checks
   `SLE_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_x <= cap_x)
   `SLE_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, state_ff != sle_pkg::S_IDLE)
   `SLE_ASSERT_IMPL(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff == sle_pkg::S_FINISH))

endmodule

/* hdl/sle_store.sv */
// ----------------------------------------------------------------------------
// sle_store
// Element memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sle_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic signed [31:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic signed [31:0] rd_data
);

   logic signed [31:0] mem_ff [DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/sle_cmp.sv */
// ----------------------------------------------------------------------------
// sle_cmp
// Shared word comparator: equality for locate, signed greater for the sort.
// ----------------------------------------------------------------------------
module sle_cmp (
   input  logic signed [31:0]  a,
   input  logic signed [31:0]  b,
   output sle_pkg::cmp_res_type res
);

   always_comb begin
      res.eq = (a == b);
      res.gt = (a > b);
   end

endmodule
